[rtl/lzw_pkg.sv]
// lzw_pkg: shared types and constants of the LZW byte compressor.
// No dependencies; imported by lzw_byte_compressor_core.
package lzw_pkg;

    localparam int BYTE_W      = 8;
    localparam int OUT_W       = 12;
    localparam int EPOCH_W     = 8;
    localparam int FIRST_FREE  = 256;

    // hash mixing
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;
    localparam int HASH_SHIFT_A = 7;
    localparam int HASH_SHIFT_B = 15;

    // remainder unit: reciprocal multiply, low-bit subtract, one correction
    localparam int HASH_W      = 32;
    localparam int MOD_CYCLES  = 3;
    localparam int MOD_STEP_W  = $clog2(MOD_CYCLES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_REDUCE,
        S_MOD,
        S_PROBE,
        S_CHECK,
        S_EMIT
    } lzw_state_t;

endpackage

[rtl/lzw_byte_compressor_core.sv]
// lzw_byte_compressor_core: LZW compressor, bytes in, codes out.
// Depends on lzw_pkg (state type, hash and width constants).

// Takes one byte word per handshake (with an end-of-stream flag) and emits
// LZW codes. The dictionary is a hash table with linear probing held in one
// single-port-read, single-port-write synchronous RAM of TABLE_DEPTH entries;
// each entry carries an 8-bit epoch tag, and an entry is live only when its
// tag matches the current epoch, so the end of a stream clears the table by
// bumping the epoch. After reset, and again once every 255 streams when the
// epoch wraps, a clearing pass writes every entry, during which no byte is
// taken. The first byte of a stream is taken as the prefix. Any other byte is
// accepted, hash multiplied and reduced, goes through the remainder unit when
// TABLE_DEPTH is not a power of two, and then through the probe loop, one RAM
// read and compare per probed slot. Each emitted code then goes into the
// output register, which decouples the code side from the byte side. Codes
// are numbered from 256 up to 2^CODE_BITS-1; when the code space or the
// table is full, no more pairs are inserted. The code port carries the low 12
// bits of a code.
module lzw_byte_compressor_core #(
    parameter int CODE_BITS   = 12,
    parameter int TABLE_DEPTH = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        code_valid,
    input  logic        code_stall,
    output logic [11:0] code,
    output logic        last_code
);
    import lzw_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int NF_W  = CODE_BITS + 1;
    localparam bit DEPTH_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [NF_W-1:0]  NF_RESET  = NF_W'(FIRST_FREE);
    localparam logic [NF_W-1:0]  NF_LIMIT  = NF_W'(1) << CODE_BITS;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [HASH_W-1:0]  RECIP = HASH_W'((64'd1 << HASH_W) / TABLE_DEPTH);

    typedef struct packed {
        logic [EPOCH_W-1:0]   epoch;
        logic [CODE_BITS-1:0] pre;
        logic [BYTE_W-1:0]    data;
        logic [CODE_BITS-1:0] code;
    } entry_t;

    // dictionary RAM
    entry_t dict_mem [TABLE_DEPTH];
    entry_t rd_q;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;

    // control
    lzw_state_t           state_reg, state_next;
    logic                 prefix_valid_reg, prefix_valid_next;
    logic [NF_W-1:0]      next_free_reg, next_free_next;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic                 clr_pend_reg, clr_pend_next;
    logic [IDX_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [1:0]           res_cnt_reg, res_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MOD_STEP_W-1:0] mod_step_reg, mod_step_next;

    // datapath
    logic [CODE_BITS-1:0] prefix_reg, prefix_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic                 eos_reg, eos_next;
    logic [HASH_W-1:0]    key_reg, key_next;
    logic [HASH_W-1:0]    prod_reg, prod_next;
    logic [HASH_W-1:0]    div_reg, div_next;
    logic [HASH_W-1:0]    quo_reg, quo_next;
    logic [IDX_W:0]       rem_reg, rem_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     probe_cnt_reg, probe_cnt_next;
    logic [CODE_BITS-1:0] res_code_reg [2];
    logic [CODE_BITS-1:0] res_code_next [2];
    logic                 res_last_reg [2];
    logic                 res_last_next [2];
    logic [CODE_BITS-1:0] out_code_reg, out_code_next;
    logic                 out_last_reg, out_last_next;

    // helpers
    logic [HASH_W-1:0]    key_raw;
    logic [HASH_W-1:0]    hash_mix;
    logic [2*HASH_W-1:0]  recip_prod;
    logic [IDX_W:0]       quo_times;
    logic [IDX_W:0]       rem_diff;
    logic                 slot_live;
    logic                 slot_match;
    logic                 out_free;
    logic                 stream_done;
    logic [CODE_BITS-1:0] final_prefix;

    assign byte_stall = (state_reg != S_IDLE);
    assign code_valid = out_valid_reg;
    assign code       = OUT_W'(out_code_reg);
    assign last_code  = out_last_reg;

    assign key_raw  = HASH_W'({prefix_reg, data_byte});
    assign hash_mix = prod_reg ^ (prod_reg >> HASH_SHIFT_B);

    assign slot_live  = (rd_q.epoch == epoch_reg);
    assign slot_match = (rd_q.pre == prefix_reg) && (rd_q.data == byte_reg);
    assign out_free   = !out_valid_reg || !code_stall;

    // remainder unit: the reciprocal quotient is low by at most one, so the
    // difference lies below 2*TABLE_DEPTH and only its low bits are needed
    assign recip_prod = (2 * HASH_W)'(div_reg) * (2 * HASH_W)'(RECIP);
    assign quo_times  = quo_reg[IDX_W:0] * DEPTH_EXT;
    assign rem_diff   = div_reg[IDX_W:0] - quo_times;

    always_comb
    begin
        state_next        = state_reg;
        prefix_valid_next = prefix_valid_reg;
        next_free_next    = next_free_reg;
        epoch_next        = epoch_reg;
        clr_pend_next     = clr_pend_reg;
        clr_addr_next     = clr_addr_reg;
        res_cnt_next      = res_cnt_reg;
        out_valid_next    = out_valid_reg;
        mod_step_next     = mod_step_reg;
        prefix_next       = prefix_reg;
        byte_next         = byte_reg;
        eos_next          = eos_reg;
        key_next          = key_reg;
        prod_next         = prod_reg;
        div_next          = div_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        idx_next          = idx_reg;
        probe_cnt_next    = probe_cnt_reg;
        res_code_next     = res_code_reg;
        res_last_next     = res_last_reg;
        out_code_next     = out_code_reg;
        out_last_next     = out_last_reg;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg;
        mem_wdata         = '0;
        stream_done       = 1'b0;
        final_prefix      = prefix_reg;

        if (out_valid_reg && !code_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == LAST_IDX)
                begin
                    clr_addr_next = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (byte_valid)
                begin
                    byte_next = data_byte;
                    eos_next  = end_of_stream;
                    if (!prefix_valid_reg)
                    begin
                        prefix_next       = CODE_BITS'(data_byte);
                        prefix_valid_next = 1'b1;
                        if (end_of_stream)
                        begin
                            res_code_next[0] = CODE_BITS'(data_byte);
                            res_last_next[0] = 1'b1;
                            res_cnt_next     = 2'd1;
                            stream_done      = 1'b1;
                            state_next       = S_EMIT;
                        end
                    end
                    else
                    begin
                        key_next   = key_raw ^ (key_raw >> HASH_SHIFT_A);
                        state_next = S_HASH;
                    end
                end
            end

            S_HASH:
            begin
                prod_next  = key_reg * HASH_MULT;
                state_next = S_REDUCE;
            end

            S_REDUCE:
            begin
                probe_cnt_next = '0;
                if (DEPTH_POW2)
                begin
                    idx_next   = hash_mix[IDX_W-1:0];
                    state_next = S_PROBE;
                end
                else
                begin
                    div_next      = hash_mix;
                    rem_next      = '0;
                    mod_step_next = '0;
                    state_next    = S_MOD;
                end
            end

            S_MOD:
            begin
                mod_step_next = mod_step_reg + 1'b1;
                if (mod_step_reg == MOD_STEP_W'(0))
                begin
                    quo_next = recip_prod[2*HASH_W-1:HASH_W];
                end
                else if (mod_step_reg == MOD_STEP_W'(1))
                begin
                    rem_next = rem_diff;
                end
                else
                begin
                    mod_step_next = '0;
                    idx_next      = (rem_reg >= DEPTH_EXT) ? IDX_W'(rem_reg - DEPTH_EXT)
                                                           : rem_reg[IDX_W-1:0];
                    state_next    = S_PROBE;
                end
            end

            S_PROBE:
            begin
                // RAM read of idx_reg lands in rd_q for the next cycle
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (slot_live && slot_match)
                begin
                    final_prefix = rd_q.code;
                    prefix_next  = rd_q.code;
                    res_cnt_next = 2'd0;
                    if (eos_reg)
                    begin
                        res_code_next[0] = rd_q.code;
                        res_last_next[0] = 1'b1;
                        res_cnt_next     = 2'd1;
                        stream_done      = 1'b1;
                    end
                    state_next = eos_reg ? S_EMIT : S_IDLE;
                end
                else if (slot_live && (probe_cnt_reg != LAST_IDX))
                begin
                    idx_next       = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    state_next     = S_PROBE;
                end
                else
                begin
                    // miss: free slot found, or the whole table was probed
                    if (!slot_live && (next_free_reg < NF_LIMIT))
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = idx_reg;
                        mem_wdata.epoch = epoch_reg;
                        mem_wdata.pre   = prefix_reg;
                        mem_wdata.data  = byte_reg;
                        mem_wdata.code  = next_free_reg[CODE_BITS-1:0];
                        next_free_next  = next_free_reg + 1'b1;
                    end
                    res_code_next[0] = prefix_reg;
                    res_last_next[0] = 1'b0;
                    res_cnt_next     = 2'd1;
                    final_prefix     = CODE_BITS'(byte_reg);
                    prefix_next      = CODE_BITS'(byte_reg);
                    if (eos_reg)
                    begin
                        res_code_next[1] = CODE_BITS'(byte_reg);
                        res_last_next[1] = 1'b1;
                        res_cnt_next     = 2'd2;
                        stream_done      = 1'b1;
                    end
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_code_next    = res_code_reg[0];
                    out_last_next    = res_last_reg[0];
                    res_code_next[0] = res_code_reg[1];
                    res_last_next[0] = res_last_reg[1];
                    res_cnt_next     = res_cnt_reg - 1'b1;
                    if (res_cnt_reg == 2'd1)
                    begin
                        if (clr_pend_reg)
                        begin
                            clr_pend_next = 1'b0;
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of stream: drop the prefix and retire the table by epoch
        if (stream_done)
        begin
            prefix_valid_next = 1'b0;
            prefix_next       = '0;
            next_free_next    = NF_RESET;
            if (epoch_reg == '1)
            begin
                epoch_next    = EPOCH_FIRST;
                clr_pend_next = 1'b1;
            end
            else
            begin
                epoch_next = epoch_reg + 1'b1;
            end
        end
        else if (state_reg == S_CHECK)
        begin
            prefix_next = final_prefix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            prefix_valid_reg <= 1'b0;
            next_free_reg    <= NF_RESET;
            epoch_reg        <= EPOCH_FIRST;
            clr_pend_reg     <= 1'b0;
            clr_addr_reg     <= '0;
            res_cnt_reg      <= 2'd0;
            out_valid_reg    <= 1'b0;
            mod_step_reg     <= '0;
            prefix_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            prefix_valid_reg <= prefix_valid_next;
            next_free_reg    <= next_free_next;
            epoch_reg        <= epoch_next;
            clr_pend_reg     <= clr_pend_next;
            clr_addr_reg     <= clr_addr_next;
            res_cnt_reg      <= res_cnt_next;
            out_valid_reg    <= out_valid_next;
            mod_step_reg     <= mod_step_next;
            prefix_reg       <= prefix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        eos_reg       <= eos_next;
        key_reg       <= key_next;
        prod_reg      <= prod_next;
        div_reg       <= div_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        idx_reg       <= idx_next;
        probe_cnt_reg <= probe_cnt_next;
        res_code_reg  <= res_code_next;
        res_last_reg  <= res_last_next;
        out_code_reg  <= out_code_next;
        out_last_reg  <= out_last_next;
    end

    // dictionary RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dict_mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= dict_mem[idx_reg];
    end

`ifndef NO_ASSERTIONS
    a_res_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EMIT) |-> (res_cnt_reg == 2'd0))
        else $error("result buffer holds codes outside the emit state");

    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch reached the cleared-entry tag");

    a_code_space: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg >= NF_RESET) && (next_free_reg <= NF_LIMIT))
        else $error("next free code out of range");

    a_lookup_start: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_stall && prefix_valid_reg) |=> (state_reg == S_HASH))
        else $error("byte with pending prefix did not start a lookup");
`endif

endmodule

[tb/tb_lzw_byte_compressor_core.sv]
// Self-checking testbench for lzw_byte_compressor_core: bytes in, LZW codes out.
// Needs only rtl/lzw_byte_compressor_core.sv (and its lzw_pkg); holds its own
// dictionary model, drives directed rows, then random streams, mostly with idling.
module tb_lzw_byte_compressor_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CODE_BITS    = 12;
    localparam int unsigned TABLE_DEPTH  = 8192;
    localparam int          CODE_LIMIT   = 1 << CODE_BITS;
    localparam int          FIRST_CODE   = 256;
    localparam int          RESET_CYCLES = 12;
    // quiet limit covers the clearing pass after reset and at the epoch wrap,
    // plus the long receiver hold-off, several times over
    localparam int          QUIET_LIMIT  = 50000;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          TAIL_CYCLES  = 64;
    localparam int          ITEM_TARGET  = 800;
    localparam int          SHORT_STREAMS = 300;
    localparam int          LONG_RANDOM  = 100;
    localparam int          LONG_TAIL    = 50;
    localparam int          DIR_ROWS     = 21;

    // one output word as the checker sees it
    typedef struct packed {
        logic [11:0] code;
        logic        is_last;
    } code_word_t;

    // directed row: the byte word, and a typed-in expectation where obvious
    typedef struct packed {
        logic [7:0]  b;
        logic        eos;
        logic        typed;
        logic [1:0]  n;
        logic [11:0] c0;
        logic        l0;
        logic [11:0] c1;
        logic        l1;
    } stim_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        byte_valid    = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte     = 8'h00;
    logic        end_of_stream = 1'b0;
    logic        code_valid;
    logic        code_stall    = 1'b0;
    logic [11:0] code;
    logic        last_code;

    always #2 clk = ~clk;

    lzw_byte_compressor_core #(
        .CODE_BITS  (CODE_BITS),
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .end_of_stream(end_of_stream),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .code         (code),
        .last_code    (last_code)
    );

    // ------------------------------------------------------------------
    // Dictionary model: own hash table with linear probing, cleared per
    // stream by walking the list of slots that were filled.
    // ------------------------------------------------------------------
    bit                   slot_used [TABLE_DEPTH];
    logic [CODE_BITS-1:0] slot_pre  [TABLE_DEPTH];
    logic [7:0]           slot_byte [TABLE_DEPTH];
    logic [12:0]          slot_code [TABLE_DEPTH];
    int unsigned          filled_slots[$];

    logic [CODE_BITS-1:0] cur_prefix  = '0;
    bit                   have_prefix = 1'b0;
    logic [12:0]          free_code   = 13'(FIRST_CODE);
    bit                   space_full  = 1'b0;

    code_word_t code_queue[$];      // codes still owed by the block

    int errors         = 0;
    int bytes_sent     = 0;
    int streams_sent   = 0;
    int codes_checked  = 0;
    int full_streams   = 0;
    bit no_idle        = 1'b0;      // last part of the run: no idling at all
    int hold_asks      = 0;         // bumped to ask the code side for a hold-off
    int send_calm      = 0;

    function automatic code_word_t make_word(input logic [11:0] c, input logic l);
        code_word_t w;
        w.code    = c;
        w.is_last = l;
        return w;
    endfunction

    function automatic int unsigned slot_hash(input logic [CODE_BITS-1:0] pre,
                                              input logic [7:0] b);
        int unsigned key;
        key = 32'({pre, b});
        key = key ^ (key >> 7);
        key = key * 32'h9E37_79B1;
        key = key ^ (key >> 15);
        return key % TABLE_DEPTH;
    endfunction

    // Advances the model by one byte; returns the 0..2 codes it produces.
    function automatic void compress_byte(input logic [7:0] b, input logic eos,
                                          output int n, output code_word_t r0,
                                          output code_word_t r1);
        int unsigned idx;
        int          hit;
        int          free_at;
        int          k;
        code_word_t  outs [2];
        n       = 0;
        outs[0] = '0;
        outs[1] = '0;
        if (!have_prefix) begin
            // first byte of a stream only becomes the prefix
            cur_prefix  = CODE_BITS'(b);
            have_prefix = 1'b1;
        end
        else begin
            idx     = slot_hash(cur_prefix, b);
            hit     = -1;
            free_at = -1;
            for (k = 0; k < int'(TABLE_DEPTH); k++) begin
                if (!slot_used[idx]) begin
                    free_at = int'(idx);
                    break;
                end
                if (slot_pre[idx] == cur_prefix && slot_byte[idx] == b) begin
                    hit = int'(idx);
                    break;
                end
                idx = (idx + 1) % TABLE_DEPTH;
            end
            if (hit >= 0)
                cur_prefix = slot_code[hit][CODE_BITS-1:0];
            else begin
                outs[n] = make_word(cur_prefix, 1'b0);
                n++;
                if (free_code < CODE_LIMIT && free_at >= 0) begin
                    slot_used[free_at] = 1'b1;
                    slot_pre[free_at]  = cur_prefix;
                    slot_byte[free_at] = b;
                    slot_code[free_at] = free_code;
                    filled_slots.push_back(free_at);
                    free_code++;
                end
                else if (free_code >= CODE_LIMIT)
                    space_full = 1'b1;
                cur_prefix = CODE_BITS'(b);
            end
        end
        if (eos) begin
            outs[n] = make_word(cur_prefix, 1'b1);
            n++;
            foreach (filled_slots[j])
                slot_used[filled_slots[j]] = 1'b0;
            filled_slots.delete();
            if (space_full)
                full_streams++;
            space_full  = 1'b0;
            cur_prefix  = '0;
            have_prefix = 1'b0;
            free_code   = 13'(FIRST_CODE);
        end
        r0 = outs[0];
        r1 = outs[1];
    endfunction

    // ------------------------------------------------------------------
    // Directed rows. Typed expectations: single-byte streams at both byte
    // extremes, the first byte of a stream, a miss and a hit chain, a miss
    // on the final byte (two codes), a hit on the final byte, and a fresh
    // stream showing the dictionary was cleared. The alternating tail rows
    // go through the model.
    // fields: byte, eos, typed, count, code0, last0, code1, last1
    // ------------------------------------------------------------------
    stim_row_t dir_rows [DIR_ROWS] = '{
        {8'h00, 1'b1, 1'b1, 2'd1, 12'h000, 1'b1, 12'h000, 1'b0},
        {8'hFF, 1'b1, 1'b1, 2'd1, 12'h0FF, 1'b1, 12'h000, 1'b0},
        {8'h41, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        {8'h42, 1'b0, 1'b1, 2'd1, 12'h041, 1'b0, 12'h000, 1'b0},
        {8'h41, 1'b0, 1'b1, 2'd1, 12'h042, 1'b0, 12'h000, 1'b0},
        {8'h42, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        {8'h41, 1'b0, 1'b1, 2'd1, 12'h100, 1'b0, 12'h000, 1'b0},
        {8'h42, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        {8'h41, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        {8'h43, 1'b1, 1'b1, 2'd2, 12'h102, 1'b0, 12'h043, 1'b1},
        {8'h07, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        {8'h07, 1'b0, 1'b1, 2'd1, 12'h007, 1'b0, 12'h000, 1'b0},
        {8'h07, 1'b1, 1'b1, 2'd1, 12'h100, 1'b1, 12'h000, 1'b0},
        {8'h41, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        {8'h42, 1'b1, 1'b1, 2'd2, 12'h041, 1'b0, 12'h042, 1'b1},
        {8'hAA, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        {8'h55, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        {8'hAA, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        {8'h55, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        {8'hAA, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        {8'h55, 1'b1, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0}
    };

    // ------------------------------------------------------------------
    // Byte side. Called at the edge where the previous word went in, so a
    // back-to-back word keeps valid high with a single assignment.
    // ------------------------------------------------------------------
    task automatic feed_byte(input logic [7:0] b, input logic eos, input logic typed,
                             input int tn, input code_word_t t0, input code_word_t t1);
        int         n;
        int         pick;
        code_word_t r0;
        code_word_t r1;
        compress_byte(b, eos, n, r0, r1);
        if (typed) begin
            n  = tn;
            r0 = t0;
            r1 = t1;
        end
        if (n > 0)
            code_queue.push_back(r0);
        if (n > 1)
            code_queue.push_back(r1);
        // sender gaps: random bursts, broken up by calm stretches
        if (!no_idle) begin
            if (send_calm > 0)
                send_calm--;
            else begin
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    send_calm = $urandom_range(20, 120);
                else if (pick < 3) begin
                    byte_valid <= 1'b0;
                    repeat ($urandom_range(1, 17)) @(posedge clk);
                end
            end
        end
        byte_valid    <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        forever begin
            @(posedge clk);
            if (!byte_stall)
                break;
        end
        bytes_sent++;
        if (eos)
            streams_sent++;
    endtask

    task automatic feed_plain(input logic [7:0] b, input logic eos);
        feed_byte(b, eos, 1'b0, 0, '0, '0);
    endtask

    // Sender stops and waits until every owed code is out.
    task automatic pause_until_drained();
        byte_valid <= 1'b0;
        while (code_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Code side: checks each accepted word against the oldest expectation
    // and drives stall. A hold-off request makes it stall for a long run
    // while the byte side keeps pushing.
    // ------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;
    int calm_left  = 0;

    always @(posedge clk) begin : code_side
        code_word_t want;
        int         pick;
        if (code_valid && !code_stall) begin
            if (code_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected code word, expected none, got code %0d last %0b",
                         $time, code, last_code);
            end
            else begin
                want = code_queue.pop_front();
                codes_checked++;
                if (code !== want.code) begin
                    errors++;
                    $display("%0t: code mismatch, expected %0d, got %0d",
                             $time, want.code, code);
                end
                if (last_code !== want.is_last) begin
                    errors++;
                    $display("%0t: last_code mismatch, expected %0b, got %0b",
                             $time, want.is_last, last_code);
                end
            end
        end
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            code_stall <= 1'b1;
        end
        else if (no_idle)
            code_stall <= 1'b0;
        else if (stall_left > 0) begin
            stall_left--;
            code_stall <= 1'b1;
        end
        else if (calm_left > 0) begin
            calm_left--;
            code_stall <= 1'b0;
        end
        else begin
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
                calm_left = $urandom_range(30, 150);
                code_stall <= 1'b0;
            end
            else if (pick < 3) begin
                stall_left = $urandom_range(1, 17) - 1;
                code_stall <= 1'b1;
            end
            else
                code_stall <= 1'b0;
        end
    end

    // Watchdog: too long without a word moving on either side.
    int quiet = 0;

    always @(posedge clk) begin : watchdog
        if (!rst_n || (byte_valid && !byte_stall) || (code_valid && !code_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t  row;
        int         len;
        int         mode;
        int         i;
        bit         paused;
        logic [7:0] base;
        logic [7:0] b;

        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (i = 0; i < DIR_ROWS; i++) begin
            row = dir_rows[i];
            feed_byte(row.b, row.eos, row.typed, int'(row.n),
                      make_word(row.c0, row.l0), make_word(row.c1, row.l1));
        end

        // many tiny streams: enough of them to wrap the table epoch, which
        // forces a second full clearing pass in the middle of traffic
        hold_asks++;
        for (i = 0; i < SHORT_STREAMS; i++) begin
            len = $urandom_range(1, 2);
            if (len == 2)
                feed_plain(8'($urandom_range(0, 255)), 1'b0);
            feed_plain(8'($urandom_range(0, 255)), 1'b1);
        end

        // general streams: random bytes, small alphabets that build long
        // dictionary chains, and runs of one byte
        hold_asks++;
        while (bytes_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 6) == 0)
                len = $urandom_range(13, 60);
            else
                len = $urandom_range(1, 12);
            mode = $urandom_range(0, 2);
            base = 8'($urandom_range(0, 255));
            for (i = 0; i < len; i++) begin
                case (mode)
                    0:       b = 8'($urandom_range(0, 255));
                    1:       b = base + 8'($urandom_range(0, 2));
                    default: b = base;
                endcase
                feed_plain(b, i == len - 1);
            end
            if (!paused && bytes_sent >= (ITEM_TARGET * 3) / 4) begin
                paused = 1'b1;
                pause_until_drained();
            end
        end

        // last part, no idling: one longer stream of random bytes that runs
        // on into a stretch from a three-byte alphabet full of hits
        no_idle = 1'b1;
        for (i = 0; i < LONG_RANDOM; i++)
            feed_plain(8'($urandom_range(0, 255)), 1'b0);
        for (i = 0; i < LONG_TAIL; i++)
            feed_plain(8'h11 * 8'($urandom_range(1, 3)), i == LONG_TAIL - 1);

        byte_valid <= 1'b0;
        while (code_queue.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d bytes in %0d streams, %0d codes checked", bytes_sent,
                 streams_sent, codes_checked);
        $display("code space ran full in %0d stream(s); %0d mismatches", full_streams,
                 errors);
        if (errors == 0 && code_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
